>>> rtl/pba_pkg.sv
package pba_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned SB_W    = 6;
  localparam int unsigned POS_W   = 22;
  localparam int unsigned WORD_IX_W = POS_W - SB_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd8;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = 7'd64;
  localparam logic [CFG_W-1:0] WIDTH_MIN   = 7'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic chk;
    logic rd_en;
    logic sel_hi;
    logic cap_lo;
    logic cap_hi;
    logic wr_en;
    logic clr;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic straddle;
    logic is_write;
    logic out_full;
    logic clr_done;
  } sts_t;

endpackage

>>> rtl/pba_ctrl.sv
module pba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  pba_pkg::sts_t sts,
  output pba_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_CHK,
    S_RD0,
    S_RD1,
    S_MRG,
    S_WR0,
    S_WR1,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en = 1'b1;
        if (sts.err) begin
          state_nxt = S_DONE;
        end else if (sts.straddle) begin
          state_nxt = S_RD1;
        end else begin
          state_nxt = S_MRG;
        end
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.sel_hi = 1'b1;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_MRG;
      end
      S_MRG: begin
        cmd.cap_lo = !sts.straddle;
        cmd.cap_hi = sts.straddle;
        state_nxt  = sts.is_write ? S_WR0 : S_DONE;
      end
      S_WR0: begin
        cmd.wr_en = 1'b1;
        state_nxt = sts.straddle ? S_WR1 : S_DONE;
      end
      S_WR1: begin
        cmd.wr_en  = 1'b1;
        cmd.sel_hi = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.res_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/pba_dpath.sv
module pba_dpath #(
  parameter int unsigned WORD_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pba_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [pba_pkg::IDX_W+pba_pkg::DATA_W-1:0] in_tdata,
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pba_pkg::DATA_W-1:0]          out_tdata,
  output logic                                out_tuser,
  input  pba_pkg::cmd_t                       cmd,
  output pba_pkg::sts_t                       sts
);

  localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned DW = pba_pkg::DATA_W;

  logic [DW-1:0] mem [WORD_COUNT];

  logic [pba_pkg::CFG_W-1:0] w_r;
  logic [pba_pkg::CFG_W-1:0] w_nxt;
  logic                      op_r;
  logic [pba_pkg::IDX_W-1:0] idx_r;
  logic [DW-1:0]             val_r;
  logic [pba_pkg::POS_W-1:0] start_r;
  logic [pba_pkg::IDX_W+pba_pkg::CFG_W-1:0] prod;
  logic [pba_pkg::POS_W-1:0] last_pos;
  logic [pba_pkg::WORD_IX_W-1:0] ew_full;
  logic [AW-1:0]             sw_r;
  logic [AW-1:0]             ew_r;
  logic [pba_pkg::SB_W-1:0]  sb_r;
  logic [DW-1:0]             m_r;
  logic [DW-1:0]             m_nxt;
  logic                      err_r;
  logic                      straddle_r;
  logic [AW-1:0]             clr_cnt_r;
  logic [DW-1:0]             rdata_r;
  logic [DW-1:0]             lo_r;
  logic [DW-1:0]             hi_r;
  logic [2*DW-1:0]           fmask;
  logic [2*DW-1:0]           fval;
  logic [2*DW-1:0]           merged;
  logic [2*DW-1:0]           shifted;
  logic [AW-1:0]             addr;
  logic                      we;
  logic [DW-1:0]             wdata;
  logic                      out_valid_r;
  logic [DW-1:0]             res_data_r;
  logic                      res_err_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      w_nxt = pba_pkg::WIDTH_MIN;
    end else if (cfg_wdata > pba_pkg::WIDTH_MAX) begin
      w_nxt = pba_pkg::WIDTH_MAX;
    end else begin
      w_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= pba_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      w_r <= w_nxt;
    end
  end

  assign prod     = idx_r * w_r;
  assign last_pos = start_r + pba_pkg::POS_W'(w_r) - pba_pkg::POS_W'(1);
  assign ew_full  = last_pos[pba_pkg::POS_W-1:pba_pkg::SB_W];
  assign m_nxt    = (w_r == pba_pkg::WIDTH_MAX) ? '1 :
                    ((DW'(1) << w_r) - DW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_tuser;
      idx_r <= in_tdata[pba_pkg::IDX_W-1:0];
      val_r <= in_tdata[pba_pkg::IDX_W +: DW];
    end
    if (cmd.mul) begin
      start_r <= prod[pba_pkg::POS_W-1:0];
    end
    if (cmd.chk) begin
      sw_r       <= AW'(start_r[pba_pkg::POS_W-1:pba_pkg::SB_W]);
      ew_r       <= AW'(ew_full);
      sb_r       <= start_r[pba_pkg::SB_W-1:0];
      m_r        <= m_nxt;
      err_r      <= {1'b0, ew_full} >= (pba_pkg::WORD_IX_W + 1)'(WORD_COUNT);
      straddle_r <= ew_full != start_r[pba_pkg::POS_W-1:pba_pkg::SB_W];
    end
    if (cmd.cap_lo) begin
      lo_r <= rdata_r;
    end
    if (cmd.cap_hi) begin
      hi_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign fmask   = {{DW{1'b0}}, m_r} << sb_r;
  assign fval    = {{DW{1'b0}}, val_r & m_r} << sb_r;
  assign merged  = ({hi_r, lo_r} & ~fmask) | fval;
  assign shifted = {hi_r, lo_r} >> sb_r;

  assign addr  = cmd.clr ? clr_cnt_r : (cmd.sel_hi ? ew_r : sw_r);
  assign we    = cmd.clr | cmd.wr_en;
  assign wdata = cmd.clr ? '0 : (cmd.sel_hi ? merged[2*DW-1:DW] : merged[DW-1:0]);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_err_r  <= err_r;
      res_data_r <= (err_r || op_r == pba_pkg::OP_WRITE) ? '0 : (shifted[DW-1:0] & m_r);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = res_data_r;
  assign out_tuser    = res_err_r;

  assign sts.err      = err_r;
  assign sts.straddle = straddle_r;
  assign sts.is_write = op_r == pba_pkg::OP_WRITE;
  assign sts.out_full = out_valid_r && !out_tready;
  assign sts.clr_done = clr_cnt_r == AW'(WORD_COUNT - 1);

endmodule

>>> rtl/packed_bitfield_array_unit.sv
// Channel  Direction  tdata (low bit up)                  tuser
// in_      slave      element_index[15:0], write_value   opcode (0 read, 1 write)
// out_     master     read_value[63:0]                    index_error
// cfg_     write      element_width[6:0] on cfg_wr_en     -
//
// One transaction at a time, sequenced over a single-port word store.
// Each transaction runs multiply, range check, one or two word reads, merge and, for a write,
// one or two word writes; an out-of-range index ends after the first word read.
// After reset a clearing pass zeroes every word of the store; in_tready stays low meanwhile.
// A finished result waits in the output register; the next transaction is accepted meanwhile.
module packed_bitfield_array_unit #(
  parameter int unsigned WORD_COUNT = 1024
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        cfg_wr_en,
  input  logic [pba_pkg::CFG_W-1:0]                   cfg_wdata,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [pba_pkg::IDX_W+pba_pkg::DATA_W-1:0]   in_tdata,  // element_index, write_value
  input  logic                                        in_tuser,  // opcode
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [pba_pkg::DATA_W-1:0]                  out_tdata, // read_value
  output logic                                        out_tuser  // index_error
);

  pba_pkg::cmd_t cmd;
  pba_pkg::sts_t sts;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pba_dpath #(
    .WORD_COUNT (WORD_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction accepted while another is in progress");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("index error with nonzero read value");

  a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (sts.is_write && !sts.err && !cmd.clr))
    else $error("store write outside a valid write transaction");

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> !sts.out_full)
    else $error("result loaded over a pending result");

endmodule

>>> test/packed_bitfield_array_unit_test.sv
module packed_bitfield_array_unit_test;

  localparam int unsigned WORDS       = 1024;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 148;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned PHASES      = 13;
  localparam int unsigned WINDOW      = 48;

  typedef struct packed {
    logic [pba_pkg::DATA_W-1:0] element;
    logic                       index_error;
  } access_result_t;

  class bitfield_store;
    bit [pba_pkg::DATA_W-1:0] words [WORDS];
    bit [pba_pkg::CFG_W-1:0]  width_reg = pba_pkg::WIDTH_RESET;
    access_result_t           expected_elements [$];
    int unsigned              errors = 0;

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > pba_pkg::WIDTH_MAX) return 64;
      return width_reg;
    endfunction

    function bit [pba_pkg::DATA_W-1:0] ones(int unsigned n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    function void set_width(bit [pba_pkg::CFG_W-1:0] v);
      width_reg = v;
    endfunction

    function int unsigned pending();
      return expected_elements.size();
    endfunction

    function void note_access(logic op, logic [pba_pkg::IDX_W-1:0] idx,
                              logic [pba_pkg::DATA_W-1:0] val);
      int unsigned              w;
      int unsigned              first_bit;
      int unsigned              last_bit;
      int unsigned              lo_word;
      int unsigned              hi_word;
      int unsigned              sb;
      int unsigned              hi_bits;
      bit [pba_pkg::DATA_W-1:0] m;
      bit [pba_pkg::DATA_W-1:0] v;
      bit [pba_pkg::DATA_W-1:0] elem;
      access_result_t           r;
      w         = active_width();
      m         = ones(w);
      first_bit = int'(idx) * w;
      last_bit  = first_bit + w - 1;
      lo_word   = first_bit >> 6;
      hi_word   = last_bit >> 6;
      sb        = first_bit & 63;
      r.element     = '0;
      r.index_error = 1'b0;
      if (hi_word >= WORDS) begin
        r.index_error = 1'b1;
      end else if (op == pba_pkg::OP_READ) begin
        elem = words[lo_word] >> sb;
        if (hi_word != lo_word) begin
          elem |= words[hi_word] << (64 - sb);
        end
        r.element = elem & m;
      end else begin
        v = val & m;
        if (hi_word == lo_word) begin
          words[lo_word] = (words[lo_word] & ~(m << sb)) | (v << sb);
        end else begin
          hi_bits = sb + w - 64;
          words[lo_word] = (words[lo_word] & ones(sb)) | (v << sb);
          words[hi_word] = (words[hi_word] & ~ones(hi_bits)) |
                           ((v >> (64 - sb)) & ones(hi_bits));
        end
      end
      expected_elements = {expected_elements, r};
    endfunction

    function void check_result(logic [pba_pkg::DATA_W-1:0] data, logic err);
      access_result_t r;
      if (expected_elements.size() == 0) begin
        $display("%0t unexpected result: expected none, got read_value %h index_error %b",
                 $time, data, err);
        errors++;
        return;
      end
      r = expected_elements.pop_front();
      if (data !== r.element) begin
        $display("%0t read_value mismatch: expected %h, got %h", $time, r.element, data);
        errors++;
      end
      if (err !== r.index_error) begin
        $display("%0t index_error mismatch: expected %b, got %b", $time, r.index_error, err);
        errors++;
      end
    endfunction
  endclass

  logic                                     clk        = 1'b0;
  logic                                     rst_n      = 1'b0;
  logic                                     cfg_wr_en  = 1'b0;
  logic [pba_pkg::CFG_W-1:0]                cfg_wdata  = '0;
  logic                                     in_tvalid  = 1'b0;
  logic                                     in_tready;
  logic [pba_pkg::IDX_W+pba_pkg::DATA_W-1:0] in_tdata  = '0;
  logic                                     in_tuser   = pba_pkg::OP_READ;
  logic                                     out_tvalid;
  logic                                     out_tready = 1'b0;
  logic [pba_pkg::DATA_W-1:0]               out_tdata;
  logic                                     out_tuser;

  bitfield_store store = new();
  bit            hold_req    = 1'b0;
  bit            quiet_phase = 1'b0;
  int unsigned   window_base = 0;

  packed_bitfield_array_unit #(
    .WORD_COUNT(WORDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      store.note_access(in_tuser, in_tdata[pba_pkg::IDX_W-1:0],
                        in_tdata[pba_pkg::IDX_W+pba_pkg::DATA_W-1:pba_pkg::IDX_W]);
    end
    if (out_tvalid && out_tready) begin
      store.check_result(out_tdata, out_tuser);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic idle_input(int unsigned n);
    if (n == 0) return;
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata  = {16'($urandom), $urandom, $urandom};
    in_tuser  = 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_access(logic op, logic [pba_pkg::IDX_W-1:0] idx,
                             logic [pba_pkg::DATA_W-1:0] val);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {val, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (store.pending() != 0) @(posedge clk);
  endtask

  task automatic write_width(logic [pba_pkg::CFG_W-1:0] v);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wdata = '0;
    store.set_width(v);
  endtask

  task automatic random_access();
    int unsigned                lim;
    int unsigned                r;
    logic [pba_pkg::IDX_W-1:0]  idx;
    logic [pba_pkg::DATA_W-1:0] val;
    logic                       op;
    lim = 65536 / store.active_width();
    r   = $urandom_range(99, 0);
    if (r < 70) begin
      idx = pba_pkg::IDX_W'(window_base + $urandom_range(WINDOW - 1, 0));
    end else if (r < 80) begin
      idx = pba_pkg::IDX_W'(lim - 1 - $urandom_range(3, 0));
    end else if (r < 90 && lim < 65536) begin
      idx = pba_pkg::IDX_W'($urandom_range(65535, lim));
    end else begin
      idx = pba_pkg::IDX_W'($urandom);
    end
    op = ($urandom_range(1, 0) == 1) ? pba_pkg::OP_WRITE : pba_pkg::OP_READ;
    r  = $urandom_range(9, 0);
    if (r == 0) val = '1;
    else if (r == 1) val = '0;
    else val = {$urandom, $urandom};
    send_access(op, idx, val);
  endtask

  initial begin
    int unsigned    n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        out_tready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (quiet_phase) begin
        out_tready = 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_tready = 1'b0;
          repeat (n - 1) @(negedge clk);
        end else begin
          out_tready = 1'b1;
          repeat ($urandom_range(8, 1) - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[packed_bitfield_array_unit] ERROR");
    $finish;
  end

  initial begin
    logic [pba_pkg::CFG_W-1:0] widths [PHASES];
    logic [pba_pkg::CFG_W-1:0] w;
    int unsigned               lim;
    widths = '{7'd1, 7'd64, 7'd13, 7'd0, 7'd127, 7'd63, 7'd33, 7'd3, 7'd65, 7'd7,
               7'd0, 7'd0, 7'd8};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_access(pba_pkg::OP_READ,  16'd0,     '0);
    send_access(pba_pkg::OP_WRITE, 16'd0,     '1);
    send_access(pba_pkg::OP_READ,  16'd0,     '0);
    send_access(pba_pkg::OP_READ,  16'd1,     '0);
    send_access(pba_pkg::OP_WRITE, 16'd1,     64'hFFFF_0000_1234_565A);
    send_access(pba_pkg::OP_READ,  16'd0,     '0);
    send_access(pba_pkg::OP_READ,  16'd1,     '0);
    send_access(pba_pkg::OP_WRITE, 16'd7,     64'h81);
    send_access(pba_pkg::OP_WRITE, 16'd8,     64'h7E);
    send_access(pba_pkg::OP_READ,  16'd7,     '0);
    send_access(pba_pkg::OP_READ,  16'd8,     '0);
    send_access(pba_pkg::OP_WRITE, 16'd8191,  64'hA5A5);
    send_access(pba_pkg::OP_READ,  16'd8191,  '0);
    send_access(pba_pkg::OP_READ,  16'd8190,  '0);
    send_access(pba_pkg::OP_READ,  16'd8192,  '0);
    send_access(pba_pkg::OP_WRITE, 16'd8192,  '1);
    send_access(pba_pkg::OP_WRITE, 16'd65535, '1);
    send_access(pba_pkg::OP_READ,  16'd65535, '0);
    send_access(pba_pkg::OP_READ,  16'd8191,  '0);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      w = widths[ph];
      if (ph == 10 || ph == 11) w = pba_pkg::CFG_W'($urandom_range(127, 0));
      write_width(w);
      lim         = 65536 / store.active_width();
      window_base = $urandom_range(lim - WINDOW, 0);
      quiet_phase = (ph % 4 == 1);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 30) hold_req = 1'b1;
        if (ph == 5 && k == 60) drain_results();
        idle_input(quiet_phase ? 0 : pick_gap());
        random_access();
      end
    end

    drain_results();
    repeat (SETTLE * 2) @(posedge clk);
    if (store.errors == 0) $display("[packed_bitfield_array_unit] OK");
    else $display("[packed_bitfield_array_unit] ERROR");
    $finish;
  end

endmodule
